@@ rtl/core/mau_pkg.sv @@
package mau_pkg;

  localparam int OpW = 4;

  localparam logic [OpW-1:0] OP_MONT_RED  = 4'd0;
  localparam logic [OpW-1:0] OP_TO_MONT   = 4'd1;
  localparam logic [OpW-1:0] OP_FROM_MONT = 4'd2;
  localparam logic [OpW-1:0] OP_REDUCE    = 4'd3;
  localparam logic [OpW-1:0] OP_COND_ADD  = 4'd4;
  localparam logic [OpW-1:0] OP_COND_SUB  = 4'd5;
  localparam logic [OpW-1:0] OP_FREEZE    = 4'd6;
  localparam logic [OpW-1:0] OP_ADD       = 4'd7;
  localparam logic [OpW-1:0] OP_SUB       = 4'd8;

  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_NEG_INVERSE = 2'd1;
  localparam logic [1:0] REG_R_SQUARED   = 2'd2;

  // remainder path: abs stage, one stage per dividend bit, sign fix stage
  localparam int DvdW     = 64;
  localparam int RemLat   = DvdW + 2;
  localparam int MontLat  = 5;
  localparam int AlignLen = RemLat - MontLat;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic [63:0]    a;
    logic [31:0]    b;
  } item_t;

  typedef struct packed {
    logic [30:0] modulus;
    logic [31:0] neg_inverse;
    logic [30:0] r_squared;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        is_rem;
    logic [31:0] res;
  } mres_t;

endpackage

@@ rtl/core/mau_mont.sv @@
module mau_mont (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  mau_pkg::item_t in_item,
  input  mau_pkg::cfg_t  cfg,
  output mau_pkg::mres_t out_res
);

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [3:0]  op1_r, op2_r, op3_r, op4_r;
  logic [63:0] a1_r, x2_r, x3_r, x4_r;
  logic [31:0] b1_r, b2_r, b3_r, b4_r;
  logic [31:0] t1_nxt, t1_r, m3_r;
  logic [62:0] mq4_r;
  logic        m4_sign_r;
  logic [31:0] res5_nxt, res5_r;
  logic        rem5_r;
  logic [31:0] q32;
  logic [63:0] m3_nxt;
  logic [64:0] s_sum;
  logic [32:0] h;
  logic [63:0] fm_sum;
  logic [31:0] a32;

  assign q32 = {1'b0, cfg.modulus};
  assign t1_nxt = in_item.a[31] ? in_item.a[31:0] + q32 : in_item.a[31:0];
  assign m3_nxt = {32'd0, x2_r[31:0]} * {32'd0, cfg.neg_inverse};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_item.op;
      a1_r  <= in_item.a;
      b1_r  <= in_item.b;
      t1_r  <= t1_nxt;
      // pre-multiply by R^2 for entry into Montgomery form
      op2_r <= op1_r;
      b2_r  <= b1_r;
      x2_r  <= (op1_r == mau_pkg::OP_TO_MONT) ?
               {32'd0, t1_r} * {33'd0, cfg.r_squared} : a1_r;
      op3_r <= op2_r;
      b3_r  <= b2_r;
      x3_r  <= x2_r;
      m3_r  <= m3_nxt[31:0];
      op4_r <= op3_r;
      b4_r  <= b3_r;
      x4_r  <= x3_r;
      mq4_r <= 63'({32'd0, m3_r} * {33'd0, cfg.modulus});
      // sign of the Montgomery factor, carried alongside the product
      m4_sign_r <= m3_r[31];
      res5_r <= res5_nxt;
      rem5_r <= (op4_r == mau_pkg::OP_REDUCE) || (op4_r == mau_pkg::OP_FREEZE);
    end
  end

  always_comb begin
    a32    = x4_r[31:0];
    s_sum  = {1'b0, x4_r} + {2'b0, mq4_r};
    h      = s_sum[64:32];
    fm_sum = {{32{a32[31]}}, a32} + {1'b0, mq4_r};
    res5_nxt = '0;
    case (op4_r)
      mau_pkg::OP_MONT_RED, mau_pkg::OP_TO_MONT: begin
        res5_nxt = (h > {2'b0, cfg.modulus}) ? 32'(h - {2'b0, cfg.modulus}) : h[31:0];
      end
      mau_pkg::OP_FROM_MONT: begin
        res5_nxt = fm_sum[63:32] - (m4_sign_r ? q32 : 32'd0);
      end
      mau_pkg::OP_COND_ADD: begin
        res5_nxt = a32[31] ? a32 + q32 : a32;
      end
      mau_pkg::OP_COND_SUB: begin
        res5_nxt = a32 - q32;
        if (res5_nxt[31]) res5_nxt = res5_nxt + q32;
      end
      mau_pkg::OP_ADD: begin
        res5_nxt = a32 + b4_r - q32;
        if (res5_nxt[31]) res5_nxt = res5_nxt + q32;
      end
      mau_pkg::OP_SUB: begin
        res5_nxt = a32 - b4_r;
        if (res5_nxt[31]) res5_nxt = res5_nxt + q32;
      end
      default: res5_nxt = '0;
    endcase
  end

  assign out_res = '{valid: v5_r, is_rem: rem5_r, res: res5_r};

endmodule

@@ rtl/core/mau_rem.sv @@
module mau_rem (
  input  logic           clk,
  input  logic           en,
  input  mau_pkg::item_t in_item,
  input  logic [30:0]    modulus,
  output logic [31:0]    rem
);

  localparam int N = mau_pkg::DvdW;

  logic [63:0] dvd_r [N+1];
  logic [31:0] r_r   [N+1];
  logic        neg_r [N+1];
  logic [63:0] val;
  logic        neg;
  logic [31:0] q32;
  logic [31:0] rem_r;

  assign q32 = {1'b0, modulus};

  always_comb begin
    if (in_item.op == mau_pkg::OP_REDUCE) begin
      val = in_item.a;
    end else begin
      val = {{32{in_item.a[31]}}, in_item.a[31:0]};
    end
    neg = val[63];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r[0] <= neg ? 64'd0 - val : val;
      r_r[0]   <= '0;
      neg_r[0] <= neg;
    end
  end

  // one quotient bit per stage: shift in a dividend bit, subtract if it fits
  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic [31:0] sh;
    assign sh = {r_r[k-1][30:0], dvd_r[k-1][63]};
    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[k] <= {dvd_r[k-1][62:0], 1'b0};
        r_r[k]   <= (sh >= q32) ? sh - q32 : sh;
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (modulus == '0) begin
        rem_r <= '0;
      end else if (neg_r[N] && r_r[N] != '0) begin
        rem_r <= q32 - r_r[N];
      end else begin
        rem_r <= r_r[N];
      end
    end
  end

  assign rem = rem_r;

endmodule

@@ rtl/core/mau_align.sv @@
module mau_align (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  mau_pkg::mres_t in_res,
  output mau_pkg::mres_t out_res
);

  localparam int L = mau_pkg::AlignLen;

  mau_pkg::mres_t dly_r [L];

  // hold the short-path result until the remainder path catches up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) dly_r[i].valid <= 1'b0;
    end else if (en) begin
      dly_r[0] <= in_res;
      for (int i = 1; i < L; i++) dly_r[i] <= dly_r[i-1];
    end
  end

  assign out_res = dly_r[L-1];

endmodule

@@ rtl/core/modular_arithmetic_unit.sv @@
// Modular arithmetic unit, 32-bit Montgomery arithmetic for an odd modulus.
// Input channel in_*: one word per request (operation code, operand_a,
// operand_b). Output channel out_*: one 32-bit result word per request, in
// request order. Configuration channel cfg_*: writes modulus (index 0),
// neg_inverse (index 1) and r_squared (index 2); cfg_ready is always high.
// Write configuration only while no request is in flight.
// Every operation has the same latency, set by the signed remainder
// path (one stage per dividend bit plus an abs and a sign-fix stage); the
// Montgomery path is shorter and is delayed to match. A new word is
// accepted every cycle while the receiver takes results.
// The pipeline advances as a whole: when a result waits and out_tready is
// low, every stage holds and in_tready drops, so nothing is lost or
// repeated. Reset clears all valid bits and the configuration registers;
// the block is ready for input in the first cycle after reset.
module modular_arithmetic_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [3:0] req_type, [67:4] operand_a, [99:68] operand_b, [103:100] zero
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] result
  output logic [31:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  mau_pkg::cfg_t  cfg_r;
  mau_pkg::item_t item;
  mau_pkg::mres_t mont_res;
  mau_pkg::mres_t tail_res;
  logic           adv;
  logic [31:0]    rem;

  assign cfg_ready = 1'b1;

  // drop writes to indexes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mau_pkg::REG_MODULUS:     cfg_r.modulus     <= cfg_data[30:0];
        mau_pkg::REG_NEG_INVERSE: cfg_r.neg_inverse <= cfg_data;
        mau_pkg::REG_R_SQUARED:   cfg_r.r_squared   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // advance the whole pipeline unless a finished word is stalled
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  assign item.op = in_tdata[3:0];
  assign item.a  = in_tdata[67:4];
  assign item.b  = in_tdata[99:68];

  mau_mont u_mont (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .in_item  (item),
    .cfg      (cfg_r),
    .out_res  (mont_res)
  );

  mau_rem u_rem (
    .clk     (clk),
    .en      (adv),
    .in_item (item),
    .modulus (cfg_r.modulus),
    .rem     (rem)
  );

  mau_align u_align (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_res  (mont_res),
    .out_res (tail_res)
  );

  assign out_tvalid = tail_res.valid;
  assign out_tdata  = tail_res.is_rem ? rem : tail_res.res;

  // a stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while output stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // remainder with zero modulus must give zero
  a_rem_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && tail_res.is_rem && cfg_r.modulus == '0) |-> out_tdata == '0)
    else $error("nonzero remainder for zero modulus");

endmodule
